// ===== rtl/assert_macros.svh =====
// assertion macros for the motion qualifier, empty when synthesized
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PMQ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PMQ_ASSERT_NEVER(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);
`else
`define PMQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define PMQ_ASSERT_NEVER(lbl, clk, rst_n, prop, msg)
`endif
`endif

// ===== rtl/pmq_pkg.sv =====
// shared types and constants of the motion qualifier
package pmq_pkg;

  localparam int CfgIdxW    = 3;
  localparam int CfgDataW   = 32;
  localparam int ReqW       = 7;
  localparam int TimeW      = 32;
  localparam int CountW     = 16;
  localparam int DurMinW    = 31;
  localparam int PeriodW    = 16;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgEnabled     = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgSamplesReq  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgDetectWin   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgCooldown    = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgDurationMin = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgSamplePer   = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgCheckPer    = 3'd6;

  localparam logic [CountW-1:0] CountMax = '1;

  typedef struct packed {
    logic               enabled;
    logic [ReqW-1:0]    highs_needed;
    logic [TimeW-1:0]   detection_window_ms;
    logic [TimeW-1:0]   cooldown_ms;
    logic [DurMinW-1:0] duration_min_ms;
    logic [PeriodW-1:0] sample_period_ms;
    logic [PeriodW-1:0] check_period_ms;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    enabled:             1'b1,
    highs_needed:        7'd3,
    detection_window_ms: 32'd5000,
    cooldown_ms:         32'd10000,
    duration_min_ms:     31'd1000,
    sample_period_ms:    16'd100,
    check_period_ms:     16'd50
  };

  typedef struct packed {
    logic [TimeW-1:0] time_ms;
    logic             sensor_level;
  } in_item_t;

  typedef struct packed {
    logic              motion_active;
    logic [CountW-1:0] motion_count;
    logic              event_done;
    logic [TimeW-1:0]  event_duration_ms;
    logic              event_significant;
  } out_item_t;

endpackage

// ===== rtl/pmq_fifo.sv =====
// small register queue used on both sides of the motion qualifier
module pmq_fifo #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// ===== rtl/pmq_core.sv =====
// motion qualification engine: sample ring, hold window, activity and event logic
module pmq_core #(
  parameter int HistoryDepth = 10
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pmq_pkg::cfg_t      cfg_i,
  input  logic               fire_i,
  input  pmq_pkg::in_item_t  item_i,
  output pmq_pkg::out_item_t res_o
);
  import pmq_pkg::*;

  localparam int PosW = (HistoryDepth > 1) ? $clog2(HistoryDepth) : 1;
  localparam int TotW = $clog2(HistoryDepth + 1);

  logic [HistoryDepth-1:0] ring_q, ring_d;
  logic [PosW-1:0]         pos_q, pos_d;
  logic [TotW-1:0]         total_q, total_d;
  logic [TimeW-1:0]        last_sample_q, last_sample_d;
  logic [TimeW-1:0]        last_check_q, last_check_d;
  logic [TimeW-1:0]        last_valid_q, last_valid_d;
  logic [TimeW-1:0]        start_q, start_d;
  logic [TimeW-1:0]        last_counted_q, last_counted_d;
  logic                    active_q, active_d;
  logic [CountW-1:0]       count_q, count_d;

  logic [TimeW-1:0] now, dur;
  logic             check_ok, sample_ok, qual, valid;
  logic             ev_done, ev_sig;

  assign now = item_i.time_ms;
  assign dur = now - start_q;

  always_comb begin
    ring_d         = ring_q;
    pos_d          = pos_q;
    total_d        = total_q;
    last_sample_d  = last_sample_q;
    last_check_d   = last_check_q;
    last_valid_d   = last_valid_q;
    start_d        = start_q;
    last_counted_d = last_counted_q;
    active_d       = active_q;
    count_d        = count_q;
    ev_done        = 1'b0;
    ev_sig         = 1'b0;
    qual           = 1'b0;
    valid          = 1'b0;

    check_ok  = ((now - last_check_q) >= {{(TimeW-PeriodW){1'b0}}, cfg_i.check_period_ms});
    sample_ok = ((now - last_sample_q) >= {{(TimeW-PeriodW){1'b0}}, cfg_i.sample_period_ms});

    if (check_ok) begin
      last_check_d = now;
      if (cfg_i.enabled) begin
        if (sample_ok) begin
          last_sample_d = now;
          // running total tracks the ring: drop the overwritten entry, add the new one
          total_d        = total_q - TotW'(ring_q[pos_q]) + TotW'(item_i.sensor_level);
          ring_d[pos_q]  = item_i.sensor_level;
          pos_d          = (pos_q == PosW'(HistoryDepth - 1)) ? '0 : pos_q + 1'b1;
          qual           = (ReqW'(total_d) >= cfg_i.highs_needed);
        end
        if (qual) begin
          last_valid_d = now;
          valid        = 1'b1;
        end else begin
          valid = ((now - last_valid_q) < cfg_i.detection_window_ms);
        end

        if (valid && !active_q) begin
          active_d = 1'b1;
          start_d  = now;
          if ((now - last_counted_q) > cfg_i.cooldown_ms) begin
            if (count_q != CountMax) begin
              count_d = count_q + 1'b1;
            end
            last_counted_d = now;
          end
        end else if (!valid && active_q) begin
          active_d = 1'b0;
          if (dur >= {1'b0, cfg_i.duration_min_ms}) begin
            ev_done = 1'b1;
            ev_sig  = (dur > {cfg_i.duration_min_ms, 1'b0});
          end
        end
      end
    end
  end

  always_comb begin
    res_o.motion_active     = active_d;
    res_o.motion_count      = count_d;
    res_o.event_done        = ev_done;
    res_o.event_duration_ms = ev_done ? dur : '0;
    res_o.event_significant = ev_sig;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_q         <= '0;
      pos_q          <= '0;
      total_q        <= '0;
      last_sample_q  <= '0;
      last_check_q   <= '0;
      last_valid_q   <= '0;
      start_q        <= '0;
      last_counted_q <= '0;
      active_q       <= 1'b0;
      count_q        <= '0;
    end else if (fire_i) begin
      ring_q         <= ring_d;
      pos_q          <= pos_d;
      total_q        <= total_d;
      last_sample_q  <= last_sample_d;
      last_check_q   <= last_check_d;
      last_valid_q   <= last_valid_d;
      start_q        <= start_d;
      last_counted_q <= last_counted_d;
      active_q       <= active_d;
      count_q        <= count_d;
    end
  end

endmodule

// ===== rtl/pir_motion_qualifier.sv =====
// top level of the motion qualifier: config registers, queues and engine
//
// the block turns timestamped raw motion-sensor levels into qualified motion:
// every pushed item yields exactly one result, which carries the active flag,
// the saturating motion count and, when motion ends after at least the
// minimum duration, an event with its duration and a significance flag.
// items enter through a small input queue (push/full) and results leave
// through a small output queue (empty/pop); the engine between them takes
// one item per cycle whenever the input queue holds one and the output queue
// has room, so the sustained rate is one item per clock cycle. an item is
// registered in the input queue; at its head, once the output queue has
// room, the engine's state update (check and sample periods, ring of
// HISTORY_DEPTH levels with a running high total, hold window, cooldown)
// computes its result straight into the output queue, from which it is
// visible on the result ports. the user must see that configuration is
// written through the cfg port only while the block is idle, which the
// block does not enforce; writes past the register list are taken and ignored
module pir_motion_qualifier #(
  parameter int HISTORY_DEPTH = 10,
  parameter int QUEUE_DEPTH   = 2
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // input queue side
  input  logic                             push,
  output logic                             full,
  input  pmq_pkg::in_item_t                in_item_i,
  // result queue side
  output logic                             empty,
  input  logic                             pop,
  output pmq_pkg::out_item_t               out_item_o,
  // configuration write channel
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [pmq_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [pmq_pkg::CfgDataW-1:0]     cfg_data_i
);
  import pmq_pkg::*;

  `include "assert_macros.svh"

  localparam int InW  = $bits(in_item_t);
  localparam int OutW = $bits(out_item_t);

  cfg_t           cfg_q, cfg_d;
  logic           cfg_we;
  logic           in_empty, out_full, core_fire;
  logic [InW-1:0] in_data;
  logic [OutW-1:0] out_data;
  in_item_t       core_item;
  out_item_t      core_res;

  // config port never stalls
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we) begin
      case (cfg_index_i)
        CfgEnabled:     cfg_d.enabled             = cfg_data_i[0];
        CfgSamplesReq:  cfg_d.highs_needed        = cfg_data_i[ReqW-1:0];
        CfgDetectWin:   cfg_d.detection_window_ms = cfg_data_i[TimeW-1:0];
        CfgCooldown:    cfg_d.cooldown_ms         = cfg_data_i[TimeW-1:0];
        CfgDurationMin: cfg_d.duration_min_ms     = cfg_data_i[DurMinW-1:0];
        CfgSamplePer:   cfg_d.sample_period_ms    = cfg_data_i[PeriodW-1:0];
        CfgCheckPer:    cfg_d.check_period_ms     = cfg_data_i[PeriodW-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // front: input queue takes transfers while not full, buffering against result backpressure
  pmq_fifo #(
    .Width (InW),
    .Depth (QUEUE_DEPTH)
  ) u_in_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (in_item_i),
    .full_o  (full),
    .pop_i   (core_fire),
    .data_o  (in_data),
    .empty_o (in_empty)
  );

  assign core_item = in_item_t'(in_data);
  // engine advances one item when there is work and somewhere to put it
  assign core_fire = !in_empty && !out_full;

  pmq_core #(
    .HistoryDepth (HISTORY_DEPTH)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .fire_i (core_fire),
    .item_i (core_item),
    .res_o  (core_res)
  );

  // back: result queue holds finished results until popped
  pmq_fifo #(
    .Width (OutW),
    .Depth (QUEUE_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (core_fire),
    .data_i  (core_res),
    .full_o  (out_full),
    .pop_i   (pop),
    .data_o  (out_data),
    .empty_o (empty)
  );

  assign out_item_o = out_item_t'(out_data);

  // a result appears only after the engine produced one
  `PMQ_ASSERT(a_result_from_engine, clk_i, rst_ni, $fell(empty) |-> $past(core_fire), "result appeared without engine transfer")
  // an ending event leaves motion inactive
  `PMQ_ASSERT(a_event_ends_motion, clk_i, rst_ni, (core_fire && core_res.event_done) |-> !core_res.motion_active, "event reported while motion active")
  // significance only accompanies an event
  `PMQ_ASSERT(a_sig_needs_event, clk_i, rst_ni, (core_fire && core_res.event_significant) |-> core_res.event_done, "significant flag without event")
  // a full input queue always has work for the engine
  `PMQ_ASSERT_NEVER(a_full_not_empty, clk_i, rst_ni, full && in_empty, "input queue full and empty at once")

endmodule

// ===== test/tb_pir_motion_qualifier.sv =====
// testbench for pir_motion_qualifier: streams timestamped sensor levels, predicts and checks results
module tb_pir_motion_qualifier;
  timeunit 1ns;
  timeprecision 1ps;

  import pmq_pkg::*;

  localparam int HistDepth  = 10;
  localparam int MaxShown   = 10;
  localparam int CycleLimit = 1_000_000;
  // back to back starts and ends at one millisecond steps
  localparam int BurstItems = 80;
  // an index past the register list, taken and ignored by the block
  localparam logic [CfgIdxW-1:0] CfgUnused = 3'd7;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                push_q      = 1'b0;
  logic                full_w;
  in_item_t            item_q      = '0;
  logic                empty_w;
  logic                pop_q       = 1'b0;
  out_item_t           res_w;
  logic                cfg_valid_q = 1'b0;
  logic                cfg_ready_w;
  logic [CfgIdxW-1:0]  cfg_index_q = '0;
  logic [CfgDataW-1:0] cfg_data_q  = '0;

  pir_motion_qualifier #(.HISTORY_DEPTH(HistDepth)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push_q),
    .full        (full_w),
    .in_item_i   (item_q),
    .empty       (empty_w),
    .pop         (pop_q),
    .out_item_o  (res_w),
    .cfg_valid_i (cfg_valid_q),
    .cfg_ready_o (cfg_ready_w),
    .cfg_index_i (cfg_index_q),
    .cfg_data_i  (cfg_data_q)
  );

  // 2 ns period
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // predictor copy of the registers and of the qualifier state, at reset values
  cfg_t                 cfg_m       = CfgReset;
  logic [HistDepth-1:0] ring_m      = '0;
  int unsigned          ring_pos_m  = 0;
  logic [TimeW-1:0]     sample_t_m  = '0;
  logic [TimeW-1:0]     check_t_m   = '0;
  logic [TimeW-1:0]     valid_t_m   = '0;
  logic [TimeW-1:0]     start_t_m   = '0;
  logic [TimeW-1:0]     counted_t_m = '0;
  logic                 active_m    = 1'b0;
  logic [CountW-1:0]    count_m     = '0;

  // results predicted for accepted samples, oldest first
  out_item_t   pending_results[$];
  int unsigned err_count   = 0;
  int unsigned cycle_count = 0;
  // when clear, neither side inserts gaps
  bit          idle_on     = 1'b1;
  int unsigned rx_stall    = 0;
  // running timestamp of the generated sample stream
  logic [TimeW-1:0] cur_time = '0;

  // hand-picked samples under reset settings: check period not yet elapsed,
  // hold at start-up, end of motion with event, counted start, wrap of time
  logic [TimeW:0] directed_items [21] = '{
    {32'd0, 1'b1},           {32'd30, 1'b1},          {32'd50, 1'b1},
    {32'd150, 1'b1},         {32'd250, 1'b1},         {32'd350, 1'b1},
    {32'd20000, 1'b0},       {32'd20100, 1'b1},       {32'd20200, 1'b1},
    {32'd20300, 1'b1},       {32'd20400, 1'b0},       {32'd40000, 1'b0},
    {32'hFFFF_FF00, 1'b1},   {32'hFFFF_FFA0, 1'b1},   {32'hFFFF_FFFF, 1'b1},
    {32'h0000_0040, 1'b1},   {32'h0000_00A0, 1'b0},   {32'h8000_0000, 1'b0},
    {32'h7FFF_FFFF, 1'b1},   {32'h5555_5555, 1'b0},   {32'hAAAA_AAAA, 1'b1}
  };

  // mostly back to back, some short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // next result of the qualifier for one sample, updating the predictor state
  function automatic out_item_t qualify_motion(in_item_t smp);
    logic [TimeW-1:0] now;
    logic [TimeW-1:0] dur;
    logic             valid;
    out_item_t        res;
    res = '0;
    now = smp.time_ms;
    // all time differences wrap at 32 bits
    if (now - check_t_m >= {16'd0, cfg_m.check_period_ms}) begin
      check_t_m = now;
      if (cfg_m.enabled) begin
        valid = 1'b0;
        if (now - sample_t_m >= {16'd0, cfg_m.sample_period_ms}) begin
          sample_t_m         = now;
          ring_m[ring_pos_m] = smp.sensor_level;
          ring_pos_m         = (ring_pos_m + 1) % HistDepth;
          if ($countones(ring_m) >= cfg_m.highs_needed) begin
            valid_t_m = now;
            valid     = 1'b1;
          end
        end
        // hold valid motion for the detection window
        if (!valid) valid = (now - valid_t_m) < cfg_m.detection_window_ms;
        if (valid && !active_m) begin
          active_m  = 1'b1;
          start_t_m = now;
          if (now - counted_t_m > cfg_m.cooldown_ms) begin
            // saturating count, the start is recorded either way
            if (count_m != CountMax) count_m = count_m + 1'b1;
            counted_t_m = now;
          end
        end else if (!valid && active_m) begin
          dur      = now - start_t_m;
          active_m = 1'b0;
          if (dur >= {1'b0, cfg_m.duration_min_ms}) begin
            res.event_done        = 1'b1;
            res.event_duration_ms = dur;
            res.event_significant = {1'b0, dur} > {1'b0, cfg_m.duration_min_ms, 1'b0};
          end
        end
      end
    end
    res.motion_active = active_m;
    res.motion_count  = count_m;
    return res;
  endfunction

  // one input transfer, then the expected result is queued
  task automatic push_sample(input in_item_t smp);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      push_q <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push_q <= 1'b1;
    item_q <= smp;
    @(posedge clk_i);
    while (full_w) @(posedge clk_i);
    pending_results.push_back(qualify_motion(smp));
  endtask

  // stop sending and let every pending result drain out
  task automatic wait_idle();
    push_q <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid_q <= 1'b1;
    cfg_index_q <= idx;
    cfg_data_q  <= data;
    @(posedge clk_i);
    while (!cfg_ready_w) @(posedge clk_i);
    case (idx)
      CfgEnabled:     cfg_m.enabled             = data[0];
      CfgSamplesReq:  cfg_m.highs_needed        = data[ReqW-1:0];
      CfgDetectWin:   cfg_m.detection_window_ms = data;
      CfgCooldown:    cfg_m.cooldown_ms         = data;
      CfgDurationMin: cfg_m.duration_min_ms     = data[DurMinW-1:0];
      CfgSamplePer:   cfg_m.sample_period_ms    = data[PeriodW-1:0];
      CfgCheckPer:    cfg_m.check_period_ms     = data[PeriodW-1:0];
      default: ;
    endcase
    cfg_valid_q <= 1'b0;
    @(posedge clk_i);
  endtask

  // full register set, written only once the block is idle
  task automatic set_config(input cfg_t c);
    wait_idle();
    write_reg(CfgEnabled,     {31'd0, c.enabled});
    write_reg(CfgSamplesReq,  {25'd0, c.highs_needed});
    write_reg(CfgDetectWin,   c.detection_window_ms);
    write_reg(CfgCooldown,    c.cooldown_ms);
    write_reg(CfgDurationMin, {1'b0, c.duration_min_ms});
    write_reg(CfgSamplePer,   {16'd0, c.sample_period_ms});
    write_reg(CfgCheckPer,    {16'd0, c.check_period_ms});
  endtask

  // runs of high and low levels with random time steps, plus some noise:
  // flipped levels inside a run and jumps to a random timestamp
  task automatic drive_motion(input int n, input int unsigned step_max);
    int unsigned r;
    int          run_left;
    bit          lvl;
    in_item_t    smp;
    run_left = 0;
    lvl      = $urandom_range(0, 1);
    for (int i = 0; i < n; i++) begin
      if (run_left == 0) begin
        lvl      = !lvl;
        run_left = lvl ? $urandom_range(2, 20) : $urandom_range(2, 40);
      end
      r = $urandom_range(0, 99);
      if (r < 3) cur_time = $urandom;
      else cur_time = cur_time + $urandom_range(0, step_max);
      smp.time_ms      = cur_time;
      smp.sensor_level = (r >= 3 && r < 9) ? !lvl : lvl;
      push_sample(smp);
      run_left--;
    end
  endtask

  task automatic test_reset_defaults();
    for (int i = 0; i < 21; i++) push_sample(directed_items[i]);
    cur_time = directed_items[20][TimeW:1];
  endtask

  task automatic test_register_extremes();
    cfg_t c;
    c = CfgReset;
    // disabled: only the check time moves
    c.enabled = 1'b0;
    set_config(c);
    drive_motion(4, 200);
    // every run samples, every sample qualifies
    c.enabled          = 1'b1;
    c.highs_needed     = '0;
    c.sample_period_ms = '0;
    c.check_period_ms  = '0;
    set_config(c);
    drive_motion(8, 3);
    // more highs required than the ring holds
    c.highs_needed = 7'd11;
    set_config(c);
    drive_motion(4, 100);
    c.highs_needed = 7'd64;
    set_config(c);
    drive_motion(4, 100);
    c.highs_needed = '1;
    set_config(c);
    drive_motion(4, 100);
    // no hold, no cooldown, every ended motion reported
    c.highs_needed        = 7'd3;
    c.detection_window_ms = '0;
    c.cooldown_ms         = '0;
    c.duration_min_ms     = '0;
    c.sample_period_ms    = 16'd1;
    set_config(c);
    drive_motion(30, 2);
    // every time and period register at its top value
    c.detection_window_ms = '1;
    c.cooldown_ms         = '1;
    c.duration_min_ms     = '1;
    c.sample_period_ms    = '1;
    c.check_period_ms     = '1;
    set_config(c);
    drive_motion(10, 70000);
    // write to an unused index changes nothing
    wait_idle();
    write_reg(CfgUnused, $urandom);
    drive_motion(3, 70000);
  endtask

  task automatic test_random_phases();
    cfg_t        c;
    int unsigned step_max;
    for (int p = 0; p < 8; p++) begin
      c.enabled = ($urandom_range(0, 9) != 0);
      if ($urandom_range(0, 9) == 0) c.highs_needed = $urandom_range(0, 1) ? 7'd64 : 7'd127;
      else c.highs_needed = $urandom_range(0, 11);
      c.sample_period_ms    = ($urandom_range(0, 9) == 0) ? 16'd0 : $urandom_range(1, 30);
      c.check_period_ms     = $urandom_range(0, c.sample_period_ms);
      c.detection_window_ms = $urandom_range(0, 300);
      c.cooldown_ms         = $urandom_range(0, 800);
      c.duration_min_ms     = $urandom_range(0, 200);
      // one phase streams with no gaps on either side
      idle_on = (p != 2);
      set_config(c);
      step_max = 2 * c.sample_period_ms + 5;
      if (p == 4) begin
        // sender holds off until the result queue has drained
        drive_motion(40, step_max);
        wait_idle();
        drive_motion(40, step_max);
      end else begin
        drive_motion(80, step_max);
      end
    end
    idle_on = 1'b1;
  endtask

  // alternate start and end of motion every other millisecond with no gaps,
  // counting each start and crossing the 32-bit time wrap on the way
  task automatic test_rapid_restarts();
    cfg_t     c;
    in_item_t smp;
    c                     = CfgReset;
    c.highs_needed        = '0;
    c.detection_window_ms = 32'd1;
    c.cooldown_ms         = '0;
    c.duration_min_ms     = '0;
    c.sample_period_ms    = 16'd2;
    c.check_period_ms     = '0;
    idle_on = 1'b0;
    set_config(c);
    cur_time = 32'hFFFF_FFD8;
    for (int i = 0; i < BurstItems; i++) begin
      cur_time         = cur_time + 1'b1;
      smp.time_ms      = cur_time;
      smp.sensor_level = $urandom_range(0, 1);
      push_sample(smp);
    end
    idle_on = 1'b1;
  endtask

  // result side: random pop stalls, each transfer checked against the oldest prediction
  always @(posedge clk_i) begin
    out_item_t exp_r;
    if (rst_ni) begin
      if (pop_q && !empty_w) begin
        if (pending_results.size() == 0) begin
          err_count++;
          if (err_count <= MaxShown)
            $display("result with nothing pending: active %0b count %0d done %0b dur %0d sig %0b",
                     res_w.motion_active, res_w.motion_count, res_w.event_done,
                     res_w.event_duration_ms, res_w.event_significant);
        end else begin
          exp_r = pending_results.pop_front();
          if (res_w.motion_active !== exp_r.motion_active ||
              res_w.motion_count !== exp_r.motion_count ||
              res_w.event_done !== exp_r.event_done ||
              res_w.event_duration_ms !== exp_r.event_duration_ms ||
              res_w.event_significant !== exp_r.event_significant) begin
            err_count++;
            if (err_count <= MaxShown)
              $display("mismatch: expected active %0b count %0d done %0b dur %0d sig %0b, %s",
                       exp_r.motion_active, exp_r.motion_count, exp_r.event_done,
                       exp_r.event_duration_ms, exp_r.event_significant,
                       $sformatf("got active %0b count %0d done %0b dur %0d sig %0b",
                                 res_w.motion_active, res_w.motion_count, res_w.event_done,
                                 res_w.event_duration_ms, res_w.event_significant));
          end
        end
      end
      if (rx_stall > 0) begin
        rx_stall--;
        pop_q <= 1'b0;
      end else begin
        pop_q <= 1'b1;
        rx_stall = pick_gap();
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("[pir_motion_qualifier] ERROR");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_register_extremes();
    test_random_phases();
    test_rapid_restarts();
    wait_idle();
    if (err_count == 0) begin
      $display("[pir_motion_qualifier] OK");
    end else begin
      $display("[pir_motion_qualifier] ERROR");
    end
    $finish;
  end

endmodule
